// File: sv/ipi_pkg.sv
// ============================================================================
// ipi_pkg: shared definitions for the indentation paren inserter
// Depths, field widths, token codes and the records passed between the parts.
// ============================================================================
package ipi_pkg;

    // Storage depths.
    localparam int STACK_DEPTH = 16;
    localparam int HOLD_DEPTH  = 16;
    localparam int QUEUE_DEPTH = 2;

    // Counter and index widths derived from the depths.
    localparam int SC_W = $clog2(STACK_DEPTH + 1);
    localparam int SI_W = $clog2(STACK_DEPTH);
    localparam int HC_W = $clog2(HOLD_DEPTH + 1);
    localparam int HI_W = $clog2(HOLD_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int QI_W = $clog2(QUEUE_DEPTH);

    // Input mode codes.
    localparam logic [2:0] MODE_WORD   = 3'd0;
    localparam logic [2:0] MODE_OPEN   = 3'd1;
    localparam logic [2:0] MODE_CLOSE  = 3'd2;
    localparam logic [2:0] MODE_QUOTE  = 3'd3;
    localparam logic [2:0] MODE_INDENT = 3'd4;
    localparam logic [2:0] MODE_EOS    = 3'd5;

    // Output token kinds.
    localparam logic [1:0] KIND_WORD  = 2'd0;
    localparam logic [1:0] KIND_OPEN  = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;
    localparam logic [1:0] KIND_QUOTE = 2'd3;

    // Explicit depth saturation limits.
    localparam logic signed [15:0] DEPTH_MAX = 16'sh7FFF;
    localparam logic signed [15:0] DEPTH_MIN = 16'sh8000;

    // Classified operation as stored in the queue.
    typedef enum logic [2:0] {
        OP_WORD   = 3'd0,
        OP_OPEN   = 3'd1,
        OP_CLOSE  = 3'd2,
        OP_QUOTE  = 3'd3,
        OP_INDENT = 3'd4,
        OP_EOS    = 3'd5
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] id;
        logic [7:0]  lvl;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] id;
        logic [7:0]  lvl;
    } held_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] id;
        logic [7:0]  ind;
        logic        inserted;
        logic        unbalanced;
        logic        overflow;
    } result_t;

    // Back end to output stage: put a result, or close off the current request.
    typedef struct packed {
        logic put;
        logic fin;
    } res_ctl_t;

    // Token kind of an operation that passes through as a token.
    function automatic logic [1:0] kind_of(op_t op);
        logic [1:0] k;
        k = KIND_WORD;
        case (op)
            OP_OPEN:  k = KIND_OPEN;
            OP_CLOSE: k = KIND_CLOSE;
            OP_QUOTE: k = KIND_QUOTE;
            default:  k = KIND_WORD;
        endcase
        return k;
    endfunction

endpackage

// File: sv/ipi_front.sv
// ============================================================================
// ipi_front: request classifier and command queue
// Decodes the mode of each request and queues it for the back end; undefined
// modes are accepted and dropped here.
// ============================================================================
module ipi_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tok_valid,
    output logic               tok_ready,
    input  logic [2:0]         mode,
    input  logic [15:0]        token_id,
    input  logic [7:0]         indent_level,
    output logic               q_valid,
    input  logic               q_ready,
    output ipi_pkg::cmd_t      q_data
);
    import ipi_pkg::*;

    cmd_t            mem [QUEUE_DEPTH];
    logic [QI_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QI_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0] cnt_reg, cnt_next;
    op_t             op;
    logic            keep;
    logic            push, pop;

    // Decode the mode into an operation.
    always_comb
    begin
        op   = OP_WORD;
        keep = 1'b1;
        unique case (mode)
            MODE_WORD:   op = OP_WORD;
            MODE_OPEN:   op = OP_OPEN;
            MODE_CLOSE:  op = OP_CLOSE;
            MODE_QUOTE:  op = OP_QUOTE;
            MODE_INDENT: op = OP_INDENT;
            MODE_EOS:    op = OP_EOS;
            default:     keep = 1'b0;
        endcase
    end

    assign tok_ready = (cnt_reg != QC_W'(QUEUE_DEPTH));
    assign q_valid   = (cnt_reg != '0);
    assign q_data    = mem[rd_ptr_reg];
    assign push      = tok_valid && tok_ready && keep;
    assign pop       = q_valid && q_ready;

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QI_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QI_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= '{op: op, id: token_id, lvl: indent_level};
        end
    end

endmodule

// File: sv/ipi_back.sv
// ============================================================================
// ipi_back: paren insertion sequencer
// Holds the line state, hold buffer and level stack, and steps out the
// results of one command, one result per cycle while can_put is high.
// ============================================================================
module ipi_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  ipi_pkg::cmd_t       q_data,
    input  logic                can_put,
    output ipi_pkg::res_ctl_t   ctl,
    output ipi_pkg::result_t    res
);
    import ipi_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_OPEN  = 6'b000010,
        S_FLUSH = 6'b000100,
        S_OWN   = 6'b001000,
        S_CLOSE = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic signed [15:0] depth_reg, depth_next;
    logic [1:0]         words_reg, words_next;
    logic               pals_reg, pals_next;
    logic [SC_W-1:0]    sc_reg, sc_next;
    logic [HC_W-1:0]    hc_reg, hc_next;
    logic [HC_W-1:0]    fidx_reg, fidx_next;
    logic               ovf_reg, ovf_next;
    logic               own_reg, own_next;
    logic               close_reg, close_next;
    logic               eos_reg, eos_next;
    cmd_t               cmd_reg, cmd_next;

    logic [7:0]         stack [STACK_DEPTH];
    held_t              hold  [HOLD_DEPTH];

    logic               push_en;
    logic               hold_en;
    held_t              hold_wdata;
    logic [SC_W-1:0]    sc_m1;
    logic [7:0]         top_lvl;
    held_t              tok;
    logic signed [15:0] d_emit;
    logic [1:0]         w_inc;
    logic               pals_new;
    logic               do_hold;

    assign sc_m1   = sc_reg - 1'b1;
    assign top_lvl = stack[sc_m1[SI_W-1:0]];

    // Token being emitted: a held entry while flushing, else the command's own.
    always_comb
    begin
        if (state_reg == S_FLUSH)
        begin
            tok = hold[fidx_reg[HI_W-1:0]];
        end
        else
        begin
            tok = '{kind: kind_of(cmd_reg.op), id: cmd_reg.id, lvl: cmd_reg.lvl};
        end
    end

    // Saturating depth update for an emitted token.
    always_comb
    begin
        d_emit = depth_reg;
        if (tok.kind == KIND_OPEN && depth_reg != DEPTH_MAX)
        begin
            d_emit = depth_reg + 16'sd1;
        end
        else if (tok.kind == KIND_CLOSE && depth_reg != DEPTH_MIN)
        begin
            d_emit = depth_reg - 16'sd1;
        end
    end

    assign w_inc    = (words_reg == 2'd3) ? 2'd3 : words_reg + 2'd1;
    assign pals_new = pals_reg || (q_data.op == OP_OPEN && words_reg == 2'd0);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        depth_next = depth_reg;
        words_next = words_reg;
        pals_next  = pals_reg;
        sc_next    = sc_reg;
        hc_next    = hc_reg;
        fidx_next  = fidx_reg;
        ovf_next   = ovf_reg;
        own_next   = own_reg;
        close_next = close_reg;
        eos_next   = eos_reg;
        cmd_next   = cmd_reg;
        push_en    = 1'b0;
        do_hold    = 1'b0;
        q_ready    = 1'b0;
        ctl        = '0;
        res        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    cmd_next   = q_data;
                    own_next   = 1'b0;
                    close_next = 1'b0;
                    eos_next   = 1'b0;
                    case (q_data.op)
                        OP_WORD:
                        begin
                            words_next = w_inc;
                            if (w_inc < 2'd2)
                            begin
                                do_hold = 1'b1;
                            end
                            else
                            begin
                                own_next = 1'b1;
                                if (w_inc == 2'd2 && depth_reg == 16'sd0 && !pals_reg)
                                begin
                                    if (sc_reg < SC_W'(STACK_DEPTH))
                                    begin
                                        push_en = 1'b1;
                                        sc_next = sc_reg + 1'b1;
                                    end
                                    else
                                    begin
                                        ovf_next = 1'b1;
                                    end
                                    state_next = S_OPEN;
                                end
                                else
                                begin
                                    state_next = S_FLUSH;
                                end
                            end
                        end
                        OP_OPEN, OP_CLOSE:
                        begin
                            pals_next = pals_new;
                            if (words_reg < 2'd2 && depth_reg == 16'sd0 && !pals_new)
                            begin
                                do_hold = 1'b1;
                            end
                            else
                            begin
                                own_next   = 1'b1;
                                state_next = S_FLUSH;
                            end
                        end
                        OP_QUOTE:
                        begin
                            if (words_reg < 2'd2)
                            begin
                                do_hold = 1'b1;
                            end
                            else
                            begin
                                state_next = S_OWN;
                            end
                        end
                        OP_INDENT:
                        begin
                            close_next = 1'b1;
                            state_next = S_FLUSH;
                        end
                        OP_EOS:
                        begin
                            close_next = 1'b1;
                            eos_next   = 1'b1;
                            state_next = S_FLUSH;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                    // A held token causes no result; a full buffer drops it.
                    if (do_hold)
                    begin
                        if (hc_reg < HC_W'(HOLD_DEPTH))
                        begin
                            hc_next = hc_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
            end
            S_OPEN:
            begin
                if (can_put)
                begin
                    ctl.put    = 1'b1;
                    res        = '{kind: KIND_OPEN, id: '0, ind: '0, inserted: 1'b1,
                                   unbalanced: 1'b0, overflow: ovf_reg};
                    ovf_next   = 1'b0;
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (fidx_reg == hc_reg)
                begin
                    hc_next   = '0;
                    fidx_next = '0;
                    if (own_reg)
                    begin
                        state_next = S_OWN;
                    end
                    else if (close_reg)
                    begin
                        state_next = S_CLOSE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (can_put)
                begin
                    ctl.put    = 1'b1;
                    res        = '{kind: tok.kind, id: tok.id, ind: tok.lvl, inserted: 1'b0,
                                   unbalanced: d_emit[15], overflow: ovf_reg};
                    depth_next = d_emit;
                    ovf_next   = 1'b0;
                    fidx_next  = fidx_reg + 1'b1;
                end
            end
            S_OWN:
            begin
                if (can_put)
                begin
                    ctl.put    = 1'b1;
                    res        = '{kind: tok.kind, id: tok.id, ind: tok.lvl, inserted: 1'b0,
                                   unbalanced: d_emit[15], overflow: ovf_reg};
                    depth_next = d_emit;
                    ovf_next   = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_CLOSE:
            begin
                if (sc_reg != '0 && (eos_reg || cmd_reg.lvl <= top_lvl))
                begin
                    if (can_put)
                    begin
                        ctl.put  = 1'b1;
                        res      = '{kind: KIND_CLOSE, id: '0, ind: '0, inserted: 1'b1,
                                     unbalanced: 1'b0, overflow: ovf_reg};
                        ovf_next = 1'b0;
                        sc_next  = sc_m1;
                    end
                end
                else
                begin
                    // New line begins; end of stream also clears the depth.
                    words_next = 2'd0;
                    pals_next  = 1'b0;
                    if (eos_reg)
                    begin
                        depth_next = 16'sd0;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (can_put)
                begin
                    ctl.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign hold_en    = do_hold && (hc_reg < HC_W'(HOLD_DEPTH));
    assign hold_wdata = '{kind: kind_of(q_data.op), id: q_data.id, lvl: q_data.lvl};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            depth_reg <= '0;
            words_reg <= '0;
            pals_reg  <= 1'b0;
            sc_reg    <= '0;
            hc_reg    <= '0;
            fidx_reg  <= '0;
            ovf_reg   <= 1'b0;
            own_reg   <= 1'b0;
            close_reg <= 1'b0;
            eos_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            words_reg <= words_next;
            pals_reg  <= pals_next;
            sc_reg    <= sc_next;
            hc_reg    <= hc_next;
            fidx_reg  <= fidx_next;
            ovf_reg   <= ovf_next;
            own_reg   <= own_next;
            close_reg <= close_next;
            eos_reg   <= eos_next;
        end
    end

    // Current command payload.
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    // Level stack and hold buffer storage.
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            stack[sc_reg[SI_W-1:0]] <= q_data.lvl;
        end
        if (hold_en)
        begin
            hold[hc_reg[HI_W-1:0]] <= hold_wdata;
        end
    end

endmodule

// File: sv/ipi_out.sv
// ============================================================================
// ipi_out: result staging and output register
// Keeps the newest result back by one slot so that the final result of a
// request can be marked, and drives the result channel from a register.
// ============================================================================
module ipi_out (
    input  logic                clk,
    input  logic                rst_n,
    input  ipi_pkg::res_ctl_t   ctl,
    input  ipi_pkg::result_t    res,
    output logic                can_put,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [1:0]          out_kind,
    output logic [15:0]         out_token_id,
    output logic [7:0]          out_indent,
    output logic                inserted,
    output logic                unbalanced,
    output logic                overflow,
    output logic                last
);
    import ipi_pkg::*;

    logic    pend_valid_reg, pend_valid_next;
    result_t pend_reg;
    logic    o_valid_reg, o_valid_next;
    result_t o_reg;
    logic    o_last_reg;
    logic    o_free;
    logic    move;

    assign o_free  = !o_valid_reg || res_ready;
    assign can_put = !pend_valid_reg || o_free;

    // The pending result moves on when a newer one arrives or the request ends.
    assign move = pend_valid_reg && (ctl.put || ctl.fin) && o_free;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        o_valid_next    = o_valid_reg;
        if (ctl.put)
        begin
            pend_valid_next = 1'b1;
        end
        else if (ctl.fin)
        begin
            pend_valid_next = 1'b0;
        end
        if (move)
        begin
            o_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            o_valid_reg    <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            o_valid_reg    <= o_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (ctl.put)
        begin
            pend_reg <= res;
        end
        if (move)
        begin
            o_reg      <= pend_reg;
            o_last_reg <= ctl.fin;
        end
    end

    assign res_valid    = o_valid_reg;
    assign out_kind     = o_reg.kind;
    assign out_token_id = o_reg.id;
    assign out_indent   = o_reg.ind;
    assign inserted     = o_reg.inserted;
    assign unbalanced   = o_reg.unbalanced;
    assign overflow     = o_reg.overflow;
    assign last         = o_last_reg;

endmodule

// File: sv/indent_paren_inserter_top.sv
// ============================================================================
// indent_paren_inserter_top: indentation driven paren inserter
// Turns a stream of classified tokens into a token stream with implicit
// parens inserted from line indentation.
// ============================================================================
//
//  Channel   Direction  Handshake              Payload
//  tokens    in         tok_valid/tok_ready    mode, token_id, indent_level
//  results   out        res_valid/res_ready    out_kind, out_token_id, out_indent,
//                                              inserted, unbalanced, overflow, last
//
//  Requests enter a two-entry command queue whenever it has room.
//  The sequencer takes a request that is only held and gives no result for it;
//  otherwise it takes the request, puts one result per cycle while the output
//  stage has room, ends the flush and the close loop where those run, and then
//  marks the last result.
//  Reset clears all control state at once; there is no clearing pass.
//  A stalled result channel stops the sequencer only once both the output register
//  and the staging slot are full; the queue still takes requests while it has room.
//
module indent_paren_inserter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tok_valid,
    output logic        tok_ready,
    input  logic [2:0]  mode,
    input  logic [15:0] token_id,
    input  logic [7:0]  indent_level,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [1:0]  out_kind,
    output logic [15:0] out_token_id,
    output logic [7:0]  out_indent,
    output logic        inserted,
    output logic        unbalanced,
    output logic        overflow,
    output logic        last
);
    import ipi_pkg::*;

    logic     q_valid;
    logic     q_ready;
    cmd_t     q_data;
    logic     can_put;
    res_ctl_t ctl;
    result_t  res;

    // Front end: classify and queue.
    ipi_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_valid    (tok_valid),
        .tok_ready    (tok_ready),
        .mode         (mode),
        .token_id     (token_id),
        .indent_level (indent_level),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_data       (q_data)
    );

    // Back end: line state, hold buffer, level stack.
    ipi_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .can_put (can_put),
        .ctl     (ctl),
        .res     (res)
    );

    // Output staging.
    ipi_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .res          (res),
        .can_put      (can_put),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .out_kind     (out_kind),
        .out_token_id (out_token_id),
        .out_indent   (out_indent),
        .inserted     (inserted),
        .unbalanced   (unbalanced),
        .overflow     (overflow),
        .last         (last)
    );

endmodule
